// File: design/thd_pkg.sv
package thd_pkg;

    typedef struct packed {
        logic first;
        logic accum;
        logic start;
        logic sqrt_step;
        logic sqrt_round;
        logic div_init;
        logic div_step;
        logic div_next;
    } thd_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic div_last;
    } thd_stat_t;

endpackage

// File: design/thd_ctrl.sv
module thd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               last_component,
    output logic               out_valid,
    input  logic               out_stall,
    output thd_pkg::thd_cmd_t  cmd,
    input  thd_pkg::thd_stat_t stat
);
    import thd_pkg::*;

    typedef enum logic [2:0] {
        S_ACC, S_SQRT, S_ROUND, S_DINIT, S_DIV, S_OUT
    } state_t;

    state_t state_reg;
    logic   first_reg;
    logic   take;

    assign in_stall  = (state_reg != S_ACC);
    assign out_valid = (state_reg == S_OUT);
    assign take      = in_valid && (state_reg == S_ACC);

    always_comb
    begin
        cmd            = '0;
        cmd.first      = take && first_reg;
        cmd.accum      = take && !first_reg;
        cmd.start      = take && last_component;
        cmd.sqrt_step  = (state_reg == S_SQRT);
        cmd.sqrt_round = (state_reg == S_ROUND);
        cmd.div_init   = (state_reg == S_DINIT);
        cmd.div_step   = (state_reg == S_DIV);
        cmd.div_next   = (state_reg == S_DIV) && stat.div_done && !stat.div_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            first_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_ACC:
                begin
                    if (take)
                    begin
                        first_reg <= last_component;
                        if (last_component)
                            state_reg <= S_SQRT;
                    end
                end
                S_SQRT:  if (stat.sqrt_done) state_reg <= S_ROUND;
                S_ROUND: state_reg <= S_DINIT;
                S_DINIT: state_reg <= S_DIV;
                S_DIV:   if (stat.div_done && stat.div_last) state_reg <= S_OUT;
                S_OUT:   if (!out_stall) state_reg <= S_ACC;
                default: state_reg <= S_ACC;
            endcase
        end
    end
endmodule

// File: design/thd_dp.sv
module thd_dp
#(
    parameter int AMP_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic               clk,
    input  logic               comp_valid,
    input  logic [15:0]        harmonic_order,
    input  logic [31:0]        amplitude,
    input  thd_pkg::thd_cmd_t  cmd,
    output thd_pkg::thd_stat_t stat,
    output logic               result_valid,
    output logic [63:0]        harmonic_power,
    output logic [31:0]        fundamental_amp,
    output logic [31:0]        harmonic_rms,
    output logic [31:0]        thd_q15,
    output logic [31:0]        thd_milli_percent,
    output logic [15:0]        included_count,
    output logic               power_overflow
);
    import thd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    logic [31:0]            amp;
    logic [63:0]            sq;
    logic [64:0]            sum_wide;
    logic                   add_en;
    logic [63:0]            psum_next;
    logic [63:0]            psum_reg;
    logic [COUNT_WIDTH-1:0] tally_reg;
    logic                   sat_reg;
    logic [31:0]            fund_reg;
    logic                   ok_reg;

    logic [63:0] rem_reg, root_reg, probe_reg;
    logic [64:0] trial;
    logic [31:0] rms_reg;

    logic [63:0] dnum_reg;
    logic [31:0] dquo_reg;
    logic [31:0] drem_reg;
    logic [6:0]  dcnt_reg;
    logic        dsel_reg;
    logic [32:0] dshift;
    logic [32:0] ddiff;
    logic [31:0] q15_reg, milli_reg;
    logic [63:0] prod;
    logic [63:0] dividend;

    assign amp = {{(32-AMP_WIDTH){1'b0}}, amplitude[AMP_WIDTH-1:0]};
    assign sq  = {32'd0, amp} * {32'd0, amp};
    assign sum_wide = {1'b0, psum_reg} + {1'b0, sq};

    assign add_en    = cmd.accum && ok_reg && comp_valid && harmonic_order >= 16'd2;
    assign psum_next = cmd.first ? 64'd0
                     : add_en ? (sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0])
                     : psum_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.first)
        begin
            psum_reg  <= '0;
            tally_reg <= '0;
            sat_reg   <= 1'b0;
            ok_reg    <= comp_valid && harmonic_order == 16'd1 && amp != 32'd0;
            fund_reg  <= (comp_valid && harmonic_order == 16'd1) ? amp : 32'd0;
        end
        else if (add_en)
        begin
            if (sum_wide[64])
            begin
                psum_reg <= '1;
                sat_reg  <= 1'b1;
            end
            else
                psum_reg <= sum_wide[63:0];
            if (tally_reg != CountMax)
                tally_reg <= tally_reg + 1'b1;
        end
    end

    assign trial = {1'b0, root_reg} + {1'b0, probe_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            root_reg  <= '0;
            probe_reg <= 64'h4000_0000_0000_0000;
            rem_reg   <= psum_next;
        end
        else if (cmd.sqrt_step && probe_reg != 64'd0)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_reg  <= rem_reg - trial[63:0];
                root_reg <= (root_reg >> 1) + probe_reg;
            end
            else
                root_reg <= root_reg >> 1;
            probe_reg <= probe_reg >> 2;
        end
        else if (cmd.sqrt_round)
            rms_reg <= (rem_reg > root_reg && root_reg[31:0] != 32'hFFFF_FFFF)
                       ? root_reg[31:0] + 32'd1 : root_reg[31:0];
    end

    assign stat.sqrt_done = (probe_reg == 64'd0);

    assign prod     = {32'd0, rms_reg}
                      * ((dsel_reg || cmd.div_next) ? 64'd100000 : 64'd32768);
    assign dividend = prod + {33'd0, fund_reg[31:1]};
    assign dshift   = {drem_reg, dnum_reg[63]};
    assign ddiff    = dshift - {1'b0, fund_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            dsel_reg <= 1'b0;
        else if (cmd.div_next)
            dsel_reg <= 1'b1;
        if (cmd.div_init || cmd.div_next)
        begin
            dnum_reg <= dividend;
            drem_reg <= '0;
            dquo_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step && !stat.div_done)
        begin
            dnum_reg <= dnum_reg << 1;
            if (dshift >= {1'b0, fund_reg})
            begin
                drem_reg <= ddiff[31:0];
                dquo_reg <= (dquo_reg[31] ? 32'hFFFF_FFFF : {dquo_reg[30:0], 1'b1});
            end
            else
            begin
                drem_reg <= dshift[31:0];
                dquo_reg <= (dquo_reg[31] ? 32'hFFFF_FFFF : {dquo_reg[30:0], 1'b0});
            end
            dcnt_reg <= dcnt_reg + 7'd1;
        end
        if (cmd.div_step && stat.div_done)
        begin
            if (dsel_reg)
                milli_reg <= (fund_reg == 32'd0) ? 32'd0 : dquo_reg;
            else
                q15_reg <= (fund_reg == 32'd0) ? 32'd0 : dquo_reg;
        end
    end

    assign stat.div_done = (dcnt_reg == 7'd64);
    assign stat.div_last = dsel_reg;

    assign result_valid      = ok_reg;
    assign harmonic_power    = ok_reg ? psum_reg : 64'd0;
    assign fundamental_amp   = ok_reg ? fund_reg : 32'd0;
    assign harmonic_rms      = ok_reg ? rms_reg : 32'd0;
    assign thd_q15           = ok_reg ? q15_reg : 32'd0;
    assign thd_milli_percent = ok_reg ? milli_reg : 32'd0;
    assign included_count    = ok_reg ? {{(16-COUNT_WIDTH){1'b0}}, tally_reg} : 16'd0;
    assign power_overflow    = ok_reg && sat_reg;
endmodule

// File: design/total_harmonic_distortion.sv
// After the last input transfer of a run, the result is offered once the datapath
// has run 32 square-root steps, a rounding step and a divider load, then two
// 64-step restoring divides.
// Throughput: one component per cycle within a run; the next run waits until
// the result transfer completes. Reset (rst_n, async, active low) clears control.
module total_harmonic_distortion
#(
    parameter int AMP_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        comp_valid,
    input  logic [15:0] harmonic_order,
    input  logic [31:0] amplitude,
    input  logic        last_component,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_valid,
    output logic [63:0] harmonic_power,
    output logic [31:0] fundamental_amp,
    output logic [31:0] harmonic_rms,
    output logic [31:0] thd_q15,
    output logic [31:0] thd_milli_percent,
    output logic [15:0] included_count,
    output logic        power_overflow
);
    import thd_pkg::*;

    thd_cmd_t  cmd;
    thd_stat_t stat;

    thd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .last_component(last_component), .out_valid(out_valid),
        .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    thd_dp #(.AMP_WIDTH(AMP_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .clk(clk), .comp_valid(comp_valid), .harmonic_order(harmonic_order),
        .amplitude(amplitude), .cmd(cmd), .stat(stat),
        .result_valid(result_valid), .harmonic_power(harmonic_power),
        .fundamental_amp(fundamental_amp), .harmonic_rms(harmonic_rms),
        .thd_q15(thd_q15), .thd_milli_percent(thd_milli_percent),
        .included_count(included_count), .power_overflow(power_overflow)
    );
endmodule

// File: bench/total_harmonic_distortion_tb.sv
module total_harmonic_distortion_tb;

    typedef struct {
        logic        cv;
        logic [15:0] order;
        logic [31:0] amp;
        logic        last;
        bit          hold;
    } comp_t;

    typedef struct {
        logic        rv;
        logic [63:0] power;
        logic [31:0] fund;
        logic [31:0] rms;
        logic [31:0] q15;
        logic [31:0] milli;
        logic [15:0] cnt;
        logic        ovf;
    } thd_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        comp_valid;
    logic [15:0] harmonic_order;
    logic [31:0] amplitude;
    logic        last_component;
    logic        out_valid;
    logic        out_stall;
    logic        result_valid;
    logic [63:0] harmonic_power;
    logic [31:0] fundamental_amp;
    logic [31:0] harmonic_rms;
    logic [31:0] thd_q15;
    logic [31:0] thd_milli_percent;
    logic [15:0] included_count;
    logic        power_overflow;

    total_harmonic_distortion dut (.*);

    comp_t    pending_comps[$];
    thd_res_t expected_results[$];

    logic [63:0] acc_power;
    logic [15:0] acc_count;
    logic        acc_sat;
    logic [31:0] fund_amp;
    logic        fund_good;
    logic        at_run_start;

    int    errors;
    int    cycles;
    int    runs_checked;
    int    drive_wait;
    int    mon_wait;
    bit    stim_done;
    int    hold_left;
    comp_t sent_comp;
    bit    took;
    int    in_gap;
    int    out_gap;

    function automatic logic [31:0] round_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        if (v > root)
            root = root + 1;
        return (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    endfunction

    function automatic logic [31:0] ratio_scaled(logic [31:0] num, logic [31:0] den,
                                                 logic [31:0] scale);
        logic [63:0] q;
        if (den == 0)
            return 0;
        q = ({32'd0, num} * {32'd0, scale} + {32'd0, den >> 1}) / {32'd0, den};
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic predict_thd(comp_t c);
        logic [63:0] sq;
        thd_res_t r;
        if (at_run_start)
        begin
            acc_power = 0;
            acc_count = 0;
            acc_sat = 0;
            fund_good = c.cv && c.order == 1 && c.amp != 0;
            fund_amp = fund_good ? c.amp : 0;
        end
        else if (fund_good && c.cv && c.order >= 2)
        begin
            sq = {32'd0, c.amp} * {32'd0, c.amp};
            if (64'hFFFF_FFFF_FFFF_FFFF - acc_power < sq)
            begin
                acc_power = 64'hFFFF_FFFF_FFFF_FFFF;
                acc_sat = 1;
            end
            else
                acc_power = acc_power + sq;
            if (acc_count != 16'hFFFF)
                acc_count = acc_count + 1;
        end
        at_run_start = c.last;
        if (!c.last)
            return;
        r = '{default: '0};
        if (fund_good)
        begin
            r.rv = 1;
            r.power = acc_power;
            r.fund = fund_amp;
            r.rms = round_sqrt(acc_power);
            r.q15 = ratio_scaled(r.rms, fund_amp, 32768);
            r.milli = ratio_scaled(r.rms, fund_amp, 100000);
            r.cnt = acc_count;
            r.ovf = acc_sat;
        end
        expected_results.push_back(r);
    endtask

    function automatic logic [31:0] rand_amp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(1, 65535);
            3: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_comp(logic cv, logic [15:0] order, logic [31:0] amp, logic last,
                            bit hold = 0);
        comp_t c;
        c.cv = cv;
        c.order = order;
        c.amp = amp;
        c.last = last;
        c.hold = hold;
        pending_comps.push_back(c);
    endtask

    task automatic add_random_run();
        int n;
        logic [15:0] ord;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        if ($urandom_range(0, 7) == 0)
            add_comp($urandom, $urandom_range(0, 2), rand_amp(), n == 0);
        else
            add_comp(1, 1, rand_amp() | 1, n == 0);
        for (int i = 1; i <= n; i++)
        begin
            case ($urandom_range(0, 9))
                0: ord = $urandom_range(0, 1);
                1: ord = 16'hFFFF - $urandom_range(0, 1);
                2: ord = $urandom;
                default: ord = $urandom_range(2, 50);
            endcase
            add_comp($urandom_range(0, 9) != 0, ord, rand_amp(), i == n);
        end
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        at_run_start = 1;
        acc_power = 0;
        acc_count = 0;
        acc_sat = 0;
        fund_amp = 0;
        fund_good = 0;
        // directed runs
        add_comp(1, 1, 32'hFFFF_FFFF, 1);
        add_comp(1, 1, 1, 1);
        add_comp(0, 1, 100, 1);
        add_comp(1, 1, 0, 1);
        add_comp(1, 2, 100, 0);
        add_comp(1, 3, 100, 1);
        add_comp(1, 1, 32768, 0);
        add_comp(1, 2, 16384, 0);
        add_comp(1, 0, 5000, 0);
        add_comp(1, 1, 5000, 0);
        add_comp(0, 3, 5000, 0);
        add_comp(1, 16'hFFFF, 32'hFFFF_FFFF, 1);
        add_comp(1, 1, 1, 0);
        add_comp(1, 2, 32'hFFFF_FFFF, 0);
        add_comp(1, 3, 32'hFFFF_FFFF, 0);
        add_comp(1, 4, 32'hFFFF_FFFF, 1, 1);
        add_comp(1, 1, 32'hAAAA_5555, 0);
        add_comp(1, 5, 32'h5555_AAAA, 1);
        while (pending_comps.size() < 420)
            add_random_run();
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            comp_valid <= 0;
            harmonic_order <= 0;
            amplitude <= 0;
            last_component <= 0;
            drive_wait <= 0;
            stim_done <= 0;
            hold_left <= 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            in_gap = $urandom_range(0, 4);
            if (took)
            begin
                sent_comp = pending_comps.pop_front();
                predict_thd(sent_comp);
            end
            if (in_valid && in_stall)
                ;
            else if (drive_wait > 0)
            begin
                in_valid <= 0;
                drive_wait <= drive_wait - 1;
            end
            else if (hold_left > 0 && expected_results.size() != 0)
                in_valid <= 0;
            else if (pending_comps.size() == 0)
            begin
                in_valid <= 0;
                stim_done <= 1;
            end
            else if (took && sent_comp.hold)
            begin
                hold_left <= 1;
                in_valid <= 0;
            end
            else if (took && in_gap > 0)
            begin
                in_valid <= 0;
                drive_wait <= in_gap - 1;
            end
            else
            begin
                hold_left <= 0;
                in_valid <= 1;
                comp_valid <= pending_comps[0].cv;
                harmonic_order <= pending_comps[0].order;
                amplitude <= pending_comps[0].amp;
                last_component <= pending_comps[0].last;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            mon_wait <= 0;
            errors <= 0;
            runs_checked <= 0;
        end
        else
        begin
            out_gap = $urandom_range(0, 4);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result transfer at cycle %0d", cycles);
                    errors <= errors + 1;
                end
                else
                begin
                    thd_res_t e;
                    e = expected_results.pop_front();
                    if (e.rv !== result_valid || e.power !== harmonic_power
                        || e.fund !== fundamental_amp || e.rms !== harmonic_rms
                        || e.q15 !== thd_q15 || e.milli !== thd_milli_percent
                        || e.cnt !== included_count || e.ovf !== power_overflow)
                    begin
                        if (errors < 10)
                        begin
                            $display("mismatch run %0d exp v%0d p%h f%h r%h q%h m%h c%h o%0d",
                                     runs_checked, e.rv, e.power, e.fund, e.rms, e.q15,
                                     e.milli, e.cnt, e.ovf);
                            $display("                 got v%0d p%h f%h r%h q%h m%h c%h o%0d",
                                     result_valid, harmonic_power, fundamental_amp,
                                     harmonic_rms, thd_q15, thd_milli_percent,
                                     included_count, power_overflow);
                        end
                        errors <= errors + 1;
                    end
                end
                runs_checked <= runs_checked + 1;
            end
            if (mon_wait > 0)
            begin
                out_stall <= 1;
                mon_wait <= mon_wait - 1;
            end
            else if (out_valid && !out_stall || !out_stall && $urandom_range(0, 7) == 0)
            begin
                if (runs_checked % 20 < 6 || out_gap == 0)
                    out_stall <= 0;
                else
                begin
                    out_stall <= 1;
                    mon_wait <= out_gap - 1;
                end
            end
            else
                out_stall <= 0;
        end
    end

    initial
    begin
        cycles = 0;
        while (!(stim_done && expected_results.size() == 0) && cycles < 400000)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= 400000)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            repeat (200) @(posedge clk);
            $display("Checked %0d THD runs from %0d-plus components, incl. saturation",
                     runs_checked, 400);
            $display("and failed-fundamental cases; %0d mismatches", errors);
            if (errors == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
            $finish;
        end
    end

endmodule
